@@ src/pcpfl_pkg.sv @@
// Shared constants and types for the per-CPU page free list allocator.
// Field widths, operation, status and register codes, and the controller states.
// No dependencies; every file but the link RAM refers to it by scoped names.
package pcpfl_pkg;

	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned CPU_W     = 3;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OOM      = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD_ADDR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP
	} state_t;

endpackage

@@ src/pcpfl_if.sv @@
// Channel interfaces of the page allocator: request, response and register write.
// Widths come from pcpfl_pkg.
interface pcpfl_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [pcpfl_pkg::CPU_W-1:0]   cpu;
	logic [pcpfl_pkg::ADDR_W-1:0]  address;

	modport source (output valid, output operation, output cpu, output address, input ready);
	modport sink   (input valid, input operation, input cpu, input address, output ready);
endinterface

interface pcpfl_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [pcpfl_pkg::ADDR_W-1:0]    page_address;
	logic [pcpfl_pkg::STATUS_W-1:0]  status;

	modport source (output valid, output page_address, output status, input ready);
	modport sink   (input valid, input page_address, input status, output ready);
endinterface

interface pcpfl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pcpfl_pkg::CFG_IDX_W-1:0]  index;
	logic [pcpfl_pkg::ADDR_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/pcpfl_link_ram.sv @@
// Single-port-write, single-port-read synchronous RAM holding the list links.
// Read data is registered and holds while rd_en is low. No package dependency.
module pcpfl_link_ram #(
	parameter int unsigned DEPTH = 32768,
	parameter int unsigned WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/per_cpu_page_free_list.sv @@
// Per-CPU page free list allocator: top level with controller, list heads and bounds.
// Depends on pcpfl_pkg, the channel interfaces in pcpfl_if.sv and pcpfl_link_ram.
//
// Usage: req carries one item (operation, cpu, address); rsp returns exactly one
// result (page_address, status) per item, in order. cfg writes low_bound (0),
// high_bound (1) and region_base (2); it is always ready and must be written
// by the user only while idle, which the block does not enforce. Each CPU owns
// a LIFO list of page frames linked through the link RAM, one entry per page
// holding the next index and a bottom-of-list flag. A free, or an allocate
// that finds every list empty, loads its result in the execute step: the
// address checks are registered at acceptance and the push writes the link RAM
// in the execute step. An allocate that pops a page loads its result in the pop
// step, because the pop reads the link RAM at the list head in the execute step
// and the new head arrives in the next cycle; items are accepted only in idle.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the controller holds in its last step until
// the output register frees, and req.ready stays low meanwhile.
// Reset clears all lists to empty and the bound registers to zero; the link
// RAM needs no clearing because an entry is only read after a push wrote it.
module per_cpu_page_free_list #(
	parameter int unsigned CPU_COUNT  = 8,
	parameter int unsigned PAGE_COUNT = 32768,
	parameter int unsigned PAGE_BYTES = 4096
) (
	input logic           clk,
	input logic           arst_n,
	pcpfl_cfg_if.sink     cfg,
	pcpfl_req_if.sink     req,
	pcpfl_rsp_if.source   rsp
);

	localparam int unsigned IDX_W  = $clog2(PAGE_COUNT);
	localparam int unsigned SEL_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int unsigned PB_LOG = $clog2(PAGE_BYTES);
	localparam int unsigned ENT_W  = IDX_W + 1;

	// Configuration registers.
	logic [pcpfl_pkg::ADDR_W-1:0] low_q;
	logic [pcpfl_pkg::ADDR_W-1:0] high_q;
	logic [pcpfl_pkg::ADDR_W-1:0] base_q;

	// List state.
	logic [IDX_W-1:0]     head_q [CPU_COUNT];
	logic [CPU_COUNT-1:0] nonempty_q;

	// Accepted item.
	logic             op_s1;
	logic [SEL_W-1:0] cpu_s1;
	logic             bad_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [SEL_W-1:0] pop_sel_q;

	pcpfl_pkg::state_t state_q, state_d;

	// Output register.
	logic                           out_valid_q;
	logic [pcpfl_pkg::ADDR_W-1:0]   page_q;
	logic [pcpfl_pkg::STATUS_W-1:0] status_q;

	// Acceptance-side logic.
	logic [3:0]                   cpu_red;
	logic [pcpfl_pkg::ADDR_W-1:0] offset;
	logic [pcpfl_pkg::ADDR_W-1:0] pg_num;
	logic                         bad_addr;

	// Controller outputs.
	logic                           req_ready;
	logic                           slot_free;
	logic                           out_load;
	logic [pcpfl_pkg::ADDR_W-1:0]   res_page;
	logic [pcpfl_pkg::STATUS_W-1:0] res_status;
	logic                           push_en;
	logic                           pop_en;
	logic                           mem_re;
	logic                           own_ne;
	logic                           any_ne;
	logic [SEL_W-1:0]               steal_sel;
	logic [SEL_W-1:0]               pick_sel;
	logic [ENT_W-1:0]               wr_entry;
	logic [ENT_W-1:0]               rd_entry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			base_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				pcpfl_pkg::CFG_LOW_BOUND:   low_q  <= cfg.data;
				pcpfl_pkg::CFG_HIGH_BOUND:  high_q <= cfg.data;
				pcpfl_pkg::CFG_REGION_BASE: base_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Reduce the CPU number modulo CPU_COUNT by repeated subtraction.
	always_comb begin
		cpu_red = {1'b0, req.cpu};
		for (int k = 0; k < 8; k++) begin
			if (cpu_red >= 4'(CPU_COUNT)) begin
				cpu_red = cpu_red - 4'(CPU_COUNT);
			end
		end
	end

	assign offset   = req.address - base_q;
	assign pg_num   = offset >> PB_LOG;
	assign bad_addr = (req.address[PB_LOG-1:0] != '0) || (req.address < low_q)
		|| (req.address >= high_q) || (req.address < base_q)
		|| (offset[PB_LOG-1:0] != '0) || (pg_num >= 32'(PAGE_COUNT));

	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			op_s1  <= req.operation;
			cpu_s1 <= cpu_red[SEL_W-1:0];
			bad_s1 <= bad_addr;
			idx_s1 <= pg_num[IDX_W-1:0];
		end
	end

	// Own list first, otherwise the lowest-numbered list that holds a page.
	always_comb begin
		steal_sel = '0;
		for (int i = CPU_COUNT - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				steal_sel = SEL_W'(i);
			end
		end
	end

	assign own_ne   = nonempty_q[cpu_s1];
	assign any_ne   = |nonempty_q;
	assign pick_sel = own_ne ? cpu_s1 : steal_sel;
	assign wr_entry = {~own_ne, head_q[cpu_s1]};
	assign slot_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcpfl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		out_load   = 1'b0;
		res_page   = '0;
		res_status = pcpfl_pkg::STAT_OK;
		push_en    = 1'b0;
		pop_en     = 1'b0;
		mem_re     = 1'b0;
		case (state_q)
			pcpfl_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					state_d = pcpfl_pkg::ST_EXEC;
				end
			end
			pcpfl_pkg::ST_EXEC: begin
				if (op_s1 == pcpfl_pkg::OP_FREE) begin
					if (slot_free) begin
						out_load   = 1'b1;
						res_status = bad_s1 ? pcpfl_pkg::STAT_BAD_ADDR : pcpfl_pkg::STAT_OK;
						push_en    = !bad_s1;
						state_d    = pcpfl_pkg::ST_IDLE;
					end
				end else if (any_ne) begin
					mem_re  = 1'b1;
					state_d = pcpfl_pkg::ST_POP;
				end else if (slot_free) begin
					out_load   = 1'b1;
					res_status = pcpfl_pkg::STAT_OOM;
					state_d    = pcpfl_pkg::ST_IDLE;
				end
			end
			pcpfl_pkg::ST_POP: begin
				if (slot_free) begin
					out_load = 1'b1;
					pop_en   = 1'b1;
					res_page = base_q + (32'(head_q[pop_sel_q]) << PB_LOG);
					state_d  = pcpfl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pcpfl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			pop_sel_q <= pick_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
			for (int i = 0; i < CPU_COUNT; i++) begin
				head_q[i] <= '0;
			end
		end else if (push_en) begin
			head_q[cpu_s1]     <= idx_s1;
			nonempty_q[cpu_s1] <= 1'b1;
		end else if (pop_en) begin
			head_q[pop_sel_q]     <= rd_entry[IDX_W-1:0];
			nonempty_q[pop_sel_q] <= ~rd_entry[IDX_W];
		end
	end

	pcpfl_link_ram #(
		.DEPTH (PAGE_COUNT),
		.WIDTH (ENT_W)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (push_en),
		.wr_addr (idx_s1),
		.wr_data (wr_entry),
		.rd_en   (mem_re),
		.rd_addr (head_q[pick_sel]),
		.rd_data (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			page_q   <= res_page;
			status_q <= res_status;
		end
	end

	assign req.ready        = req_ready;
	assign rsp.valid        = out_valid_q;
	assign rsp.page_address = page_q;
	assign rsp.status       = status_q;

`ifndef SYNTHESIS
	// The pop step is only ever reached from the execute step or by stalling in it.
	a_pop_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcpfl_pkg::ST_POP |->
			$past(state_q) == pcpfl_pkg::ST_EXEC || $past(state_q) == pcpfl_pkg::ST_POP)
		else $error("pop step entered without a preceding execute step");

	// Out of memory is only reported when every list is empty.
	a_oom_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res_status == pcpfl_pkg::STAT_OOM |-> nonempty_q == '0)
		else $error("out of memory reported while a list holds pages");

	// A rejected free leaves the non-empty flag of every list untouched.
	a_bad_free_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcpfl_pkg::ST_EXEC && op_s1 == pcpfl_pkg::OP_FREE && bad_s1
			|=> $stable(nonempty_q))
		else $error("rejected free changed the list state");

	// A completed push leaves the target list non-empty.
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |=> nonempty_q[$past(cpu_s1)])
		else $error("list still empty after a push");

	// The link RAM is never read and written in the same cycle.
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && push_en))
		else $error("link RAM read and written together");
`endif

endmodule

@@ verif/pcpfl_result_checker.sv @@
// Checker for the per-CPU page free list allocator: mirrors the free lists and bounds,
// predicts one response per accepted request and compares it with the response channel.
// Depends on pcpfl_pkg and the channel interfaces in pcpfl_if.sv.
module pcpfl_result_checker #(
	parameter int unsigned CPU_COUNT  = 8,
	parameter int unsigned PAGE_COUNT = 32768,
	parameter int unsigned PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	pcpfl_cfg_if        cfg,
	pcpfl_req_if        req,
	pcpfl_rsp_if        rsp,
	output int unsigned fail_count,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDX_W = $clog2(PAGE_COUNT);

	typedef struct packed {
		logic [pcpfl_pkg::ADDR_W-1:0]   page_address;
		logic [pcpfl_pkg::STATUS_W-1:0] status;
	} page_answer_t;

	logic [pcpfl_pkg::ADDR_W-1:0]  low_bound;
	logic [pcpfl_pkg::ADDR_W-1:0]  high_bound;
	logic [pcpfl_pkg::ADDR_W-1:0]  region_base;
	logic [IDX_W-1:0]   link_next [PAGE_COUNT];
	logic               link_bottom [PAGE_COUNT];
	logic [IDX_W-1:0]   list_top [CPU_COUNT];
	logic [CPU_COUNT-1:0] list_full;
	page_answer_t       answers_due [$];

	// Applies one request to the mirrored lists and returns the response it must give.
	function automatic page_answer_t serve_request(input logic op,
			input logic [pcpfl_pkg::CPU_W-1:0] cpu,
			input logic [pcpfl_pkg::ADDR_W-1:0] addr);
		page_answer_t     ans;
		logic [pcpfl_pkg::ADDR_W-1:0] offset;
		logic [pcpfl_pkg::ADDR_W-1:0] page_idx;
		logic             reject;
		int unsigned      owner;
		int               i;
		logic [IDX_W-1:0] top;

		ans.page_address = '0;
		ans.status = pcpfl_pkg::STAT_OK;
		owner = cpu % CPU_COUNT;
		if (op == pcpfl_pkg::OP_FREE) begin
			offset = addr - region_base;
			page_idx = offset / PAGE_BYTES;
			reject = (addr % PAGE_BYTES != 0) || (addr < low_bound) || (addr >= high_bound)
				|| (addr < region_base) || (offset % PAGE_BYTES != 0)
				|| (page_idx >= PAGE_COUNT);
			if (reject) begin
				ans.status = pcpfl_pkg::STAT_BAD_ADDR;
			end else begin
				link_next[page_idx[IDX_W-1:0]] = list_top[owner];
				link_bottom[page_idx[IDX_W-1:0]] = !list_full[owner];
				list_top[owner] = page_idx[IDX_W-1:0];
				list_full[owner] = 1'b1;
			end
		end else begin
			// Own list first, otherwise steal from the lowest-numbered list that has a page.
			if (!list_full[owner]) begin
				owner = CPU_COUNT;
				for (i = CPU_COUNT - 1; i >= 0; i--) begin
					if (list_full[i])
						owner = i;
				end
			end
			if (owner == CPU_COUNT) begin
				ans.status = pcpfl_pkg::STAT_OOM;
			end else begin
				top = list_top[owner];
				list_full[owner] = !link_bottom[top];
				list_top[owner] = link_next[top];
				ans.page_address = region_base + pcpfl_pkg::ADDR_W'(top) * PAGE_BYTES;
			end
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		page_answer_t got;
		page_answer_t want;
		if (!arst_n) begin
			low_bound = '0;
			high_bound = '0;
			region_base = '0;
			for (int c = 0; c < CPU_COUNT; c++)
				list_top[c] = '0;
			list_full = '0;
			answers_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					pcpfl_pkg::CFG_LOW_BOUND:   low_bound = cfg.data;
					pcpfl_pkg::CFG_HIGH_BOUND:  high_bound = cfg.data;
					pcpfl_pkg::CFG_REGION_BASE: region_base = cfg.data;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got.page_address = rsp.page_address;
				got.status = rsp.status;
				if (answers_due.size() == 0) begin
					$error("response with none outstanding: page_address %h status %0d",
						got.page_address, got.status);
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					if (got.page_address !== want.page_address) begin
						$error("page_address expected %h actual %h",
							want.page_address, got.page_address);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, got.status);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				answers_due.push_back(serve_request(req.operation, req.cpu, req.address));
			pending = answers_due.size();
		end
	end

endmodule

@@ verif/per_cpu_page_free_list_tb.sv @@
// Testbench top for the per-CPU page free list allocator: clock, reset, request and
// register stimulus, receiver stalls and the verdict. Depends on pcpfl_pkg, pcpfl_if.sv,
// the block itself and pcpfl_result_checker.
module per_cpu_page_free_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CPU_COUNT  = 8;
	localparam int unsigned PAGE_COUNT = 32768;
	localparam int unsigned PAGE_BYTES = 4096;
	localparam int unsigned CYCLE_LIMIT = 500000;

	logic clk;
	logic arst_n;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned burst_left;
	int unsigned cycle_count;
	logic [pcpfl_pkg::ADDR_W-1:0] lo_cfg;
	logic [pcpfl_pkg::ADDR_W-1:0] hi_cfg;
	logic [pcpfl_pkg::ADDR_W-1:0] base_cfg;

	pcpfl_cfg_if cfg_ch ();
	pcpfl_req_if req_ch ();
	pcpfl_rsp_if rsp_ch ();

	per_cpu_page_free_list #(
		.CPU_COUNT (CPU_COUNT),
		.PAGE_COUNT(PAGE_COUNT),
		.PAGE_BYTES(PAGE_BYTES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	pcpfl_result_checker #(
		.CPU_COUNT (CPU_COUNT),
		.PAGE_COUNT(PAGE_COUNT),
		.PAGE_BYTES(PAGE_BYTES)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_ch),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fail_count(mismatches),
		.pending   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Receiver: segments of steady, random and heavy stalling, plus a long periodic
	// hold-off so the block fills up and pushes back on requests.
	initial begin
		int unsigned rx_cycles;
		int unsigned seg_left;
		int unsigned hold_left;
		int unsigned mode;
		rx_cycles = 0;
		seg_left = 0;
		hold_left = 0;
		mode = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (rx_cycles % 3000 == 1500)
				hold_left = 300;
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 2);
					seg_left = $urandom_range(10, 120);
				end
				seg_left--;
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Offers one item; bursts of random length are separated by random gaps.
	task automatic send_item(input logic op, input logic [pcpfl_pkg::CPU_W-1:0] cpu,
			input logic [pcpfl_pkg::ADDR_W-1:0] addr);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.cpu <= cpu;
		req_ch.address <= addr;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Waits until the block has drained, then writes all three registers.
	task automatic reconfigure(input logic [pcpfl_pkg::ADDR_W-1:0] lo,
			input logic [pcpfl_pkg::ADDR_W-1:0] hi,
			input logic [pcpfl_pkg::ADDR_W-1:0] base);
		req_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		wait (outstanding == 0);
		repeat (8) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= pcpfl_pkg::CFG_REGION_BASE;
		cfg_ch.data <= base;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= pcpfl_pkg::CFG_LOW_BOUND;
		cfg_ch.data <= lo;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= pcpfl_pkg::CFG_HIGH_BOUND;
		cfg_ch.data <= hi;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		lo_cfg = lo;
		hi_cfg = hi;
		base_cfg = base;
		burst_left = 0;
	endtask

	// Mostly pages from a small pool so they get reused, with edges, misaligned and noise.
	function automatic logic [pcpfl_pkg::ADDR_W-1:0] pick_free_address(
			input int unsigned pool);
		int unsigned pick;
		logic [pcpfl_pkg::ADDR_W-1:0] addr;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			addr = base_cfg + $urandom_range(0, pool - 1) * PAGE_BYTES;
		end else if (pick < 70) begin
			addr = base_cfg + $urandom_range(0, PAGE_COUNT - 1) * PAGE_BYTES;
		end else if (pick < 78) begin
			case ($urandom_range(0, 5))
				0: addr = lo_cfg;
				1: addr = lo_cfg - PAGE_BYTES;
				2: addr = hi_cfg;
				3: addr = hi_cfg - PAGE_BYTES;
				4: addr = base_cfg + (PAGE_COUNT - 1) * PAGE_BYTES;
				default: addr = base_cfg + PAGE_COUNT * PAGE_BYTES;
			endcase
		end else if (pick < 88) begin
			addr = base_cfg + $urandom_range(0, pool - 1) * PAGE_BYTES
				+ $urandom_range(1, PAGE_BYTES - 1);
		end else begin
			addr = $urandom();
		end
		return addr;
	endfunction

	task automatic random_phase(input int unsigned count, input int unsigned free_pct,
			input int unsigned pool);
		logic op;
		logic [pcpfl_pkg::CPU_W-1:0] cpu;
		for (int unsigned k = 0; k < count; k++) begin
			op = ($urandom_range(0, 99) < free_pct) ? pcpfl_pkg::OP_FREE : pcpfl_pkg::OP_ALLOC;
			// A quarter of the traffic goes to two CPUs so the others run dry and steal.
			if ($urandom_range(0, 3) == 0)
				cpu = pcpfl_pkg::CPU_W'($urandom_range(0, 1));
			else
				cpu = pcpfl_pkg::CPU_W'($urandom_range(0, CPU_COUNT - 1));
			send_item(op, cpu, (op == pcpfl_pkg::OP_FREE) ? pick_free_address(pool) : $urandom());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= pcpfl_pkg::OP_ALLOC;
		req_ch.cpu <= '0;
		req_ch.address <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= pcpfl_pkg::CFG_LOW_BOUND;
		cfg_ch.data <= '0;
		burst_left = 0;
		lo_cfg = '0;
		hi_cfg = '0;
		base_cfg = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Bounds still at zero: nothing to allocate and every free is rejected.
		send_item(pcpfl_pkg::OP_ALLOC, 3'd0, 32'h0);
		send_item(pcpfl_pkg::OP_FREE, 3'd7, 32'h0);
		send_item(pcpfl_pkg::OP_FREE, 3'd7, 32'hFFFF_FFFF);

		reconfigure(32'h0010_0000, 32'h0800_0000, 32'h0);
		send_item(pcpfl_pkg::OP_FREE, 3'd3, 32'h000F_F000);
		send_item(pcpfl_pkg::OP_FREE, 3'd3, 32'h0010_0001);
		send_item(pcpfl_pkg::OP_FREE, 3'd3, 32'h0800_0000);
		send_item(pcpfl_pkg::OP_FREE, 3'd3, 32'h07FF_F000);
		send_item(pcpfl_pkg::OP_FREE, 3'd3, 32'h0010_0000);
		send_item(pcpfl_pkg::OP_FREE, 3'd0, 32'h0010_1000);
		send_item(pcpfl_pkg::OP_ALLOC, 3'd3, 32'hFFFF_FFFF);
		send_item(pcpfl_pkg::OP_ALLOC, 3'd3, 32'h0);
		send_item(pcpfl_pkg::OP_ALLOC, 3'd5, 32'h0);
		send_item(pcpfl_pkg::OP_ALLOC, 3'd7, 32'h0);
		send_item(pcpfl_pkg::OP_FREE, 3'd7, 32'h0010_2000);
		send_item(pcpfl_pkg::OP_ALLOC, 3'd7, 32'h0);
		random_phase(400, 55, 64);

		reconfigure(32'h0, 32'hFFFF_FFFF, 32'hF800_0000);
		send_item(pcpfl_pkg::OP_FREE, 3'd6, 32'hF7FF_F000);
		send_item(pcpfl_pkg::OP_FREE, 3'd6, 32'hFFFF_F000);
		send_item(pcpfl_pkg::OP_ALLOC, 3'd2, 32'h0);
		random_phase(400, 45, 64);

		// A base that is not page aligned rejects every free; pops use the odd base.
		reconfigure(32'h0, 32'hFFFF_FFFF, 32'h0000_0800);
		send_item(pcpfl_pkg::OP_FREE, 3'd1, 32'h0000_1000);
		send_item(pcpfl_pkg::OP_FREE, 3'd1, 32'h0000_1800);
		random_phase(100, 30, 64);

		// Bounds wider than the table, so only the page-count check stops the top frees.
		reconfigure(32'h0, 32'hFFFF_FFFF, 32'h1234_5000);
		send_item(pcpfl_pkg::OP_FREE, 3'd4, 32'h1234_4000);
		send_item(pcpfl_pkg::OP_FREE, 3'd4, 32'h1A34_5000);
		send_item(pcpfl_pkg::OP_FREE, 3'd4, 32'h1A34_4000);
		send_item(pcpfl_pkg::OP_ALLOC, 3'd1, 32'h0);
		random_phase(450, 55, 256);

		// Highest low bound and zero high bound: frees rejected, allocations drain the lists.
		reconfigure(32'hFFFF_FFFF, 32'h0, 32'hFFFF_F000);
		random_phase(200, 10, 64);

		req_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
